@@ hw/rtl/kfs_pkg.sv @@
package kfs_pkg;

    // Field widths
    localparam int FLOOR_W   = 14;
    localparam int KEY_W     = 4;
    localparam int OUT_TDATA_W = 48;
    localparam int IN_TDATA_W  = 8;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_D0    = 4'd0;
    localparam logic [KEY_W-1:0] KEY_D9    = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd10;
    localparam logic [KEY_W-1:0] KEY_GO    = 4'd11;

    // Item kinds carried on tuser
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Reset floor for car position and destination
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 14'd1;

    // Car and entry state, minus the digit count
    typedef struct packed {
        logic [FLOOR_W-1:0] floor_now;
        logic [FLOOR_W-1:0] destination;
        logic [FLOOR_W-1:0] typed_value;
        logic               travelling;
        logic               upward;
    } t_kfs_state;

    // Per-item event flags
    typedef struct packed {
        logic arrived;
        logic rejected;
    } t_kfs_flags;

endpackage

@@ hw/rtl/kfs_step.sv @@
module kfs_step #(
    parameter int ENTRY_DIGITS = 4,
    parameter int CNT_W        = 3
) (
    input  kfs_pkg::t_kfs_state       i_state,
    input  logic [CNT_W-1:0]          i_count,
    input  logic                      i_action,
    input  logic [kfs_pkg::KEY_W-1:0] i_key,
    output kfs_pkg::t_kfs_state       o_state,
    output logic [CNT_W-1:0]          o_count,
    output kfs_pkg::t_kfs_flags       o_flags
);
    import kfs_pkg::*;

    logic [FLOOR_W-1:0] w_times10;
    logic [FLOOR_W-1:0] w_digit_value;
    logic [FLOOR_W-1:0] w_step_floor;

    // Shift-and-add times ten, then append the digit
    assign w_times10     = {i_state.typed_value[FLOOR_W-4:0], 3'b000}
                         + {i_state.typed_value[FLOOR_W-2:0], 1'b0};
    assign w_digit_value = w_times10 + {{(FLOOR_W-KEY_W){1'b0}}, i_key};

    // Move one floor in the current direction
    assign w_step_floor = i_state.upward ? (i_state.floor_now + 1'b1)
                                         : (i_state.floor_now - 1'b1);

    always_comb begin
        o_state          = i_state;
        o_count          = i_count;
        o_flags.arrived  = 1'b0;
        o_flags.rejected = 1'b0;

        if (i_action == ACT_TICK) begin
            // Step toward the target, stop and clear entry on arrival
            if (i_state.travelling) begin
                o_state.floor_now = w_step_floor;
                if (w_step_floor == i_state.destination) begin
                    o_state.travelling  = 1'b0;
                    o_state.typed_value = '0;
                    o_count             = '0;
                    o_flags.arrived     = 1'b1;
                end
            end
        end else if (!i_state.travelling) begin
            // Keys are taken only while the car stands
            case (i_key) inside
                [KEY_D0:KEY_D9]: begin
                    if (i_count < CNT_W'(ENTRY_DIGITS)) begin
                        o_state.typed_value = w_digit_value;
                        o_count             = i_count + 1'b1;
                    end
                end
                KEY_CLEAR: begin
                    o_state.typed_value = '0;
                    o_count             = '0;
                end
                KEY_GO: begin
                    if (i_state.typed_value == i_state.floor_now) begin
                        o_state.typed_value = '0;
                        o_count             = '0;
                        o_flags.rejected    = 1'b1;
                    end else begin
                        o_state.destination = i_state.typed_value;
                        o_state.upward      = i_state.typed_value > i_state.floor_now;
                        o_state.travelling  = 1'b1;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/keypad_floor_select_stepper.sv @@
// Keypad floor selector with a one-floor-per-tick stepper. Each input item is
// either a key event (tuser = 0, key code in tdata) or a movement tick
// (tuser = 1), and every item yields exactly one result item carrying the car
// floor, the target, the typed entry and the moving/direction/arrival/reject
// flags. The block takes one item per clock cycle unless the result side is
// stalled by m_axis_tready; each item passes the input register, then the
// combinational state update that feeds the result register. Digits
// build an entry of up to ENTRY_DIGITS decimal digits, clear empties it, go
// starts a move (empty entry means floor 0) or flags a reject when the target
// is the current floor. Keys are ignored while moving. After reset the car
// stands at floor 1.
module keypad_floor_select_stepper #(
    parameter int ENTRY_DIGITS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] key_code, [7:4] zero
    input  logic [kfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] action
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [13:0] current_floor, [27:14] target_floor, [41:28] entry_value,
    // [42] moving, [43] going_up, [44] arrived, [45] rejected, [47:46] zero
    output logic [kfs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import kfs_pkg::*;

    localparam int CNT_W = $clog2(ENTRY_DIGITS + 1);

    logic                   r_in_valid;
    logic                   r_in_action;
    logic [KEY_W-1:0]       r_in_key;
    t_kfs_state             r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_kfs_state             n_state;
    logic [CNT_W-1:0]       n_count;
    t_kfs_flags             w_flags;
    logic                   w_advance;
    logic                   w_in_take;

    // Move the staged item forward when the result slot is free or drains
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (w_in_take) begin
            r_in_action <= s_axis_tuser;
            r_in_key    <= s_axis_tdata[KEY_W-1:0];
        end
    end

    kfs_step #(
        .ENTRY_DIGITS (ENTRY_DIGITS),
        .CNT_W        (CNT_W)
    ) u_step (
        .i_state  (r_state),
        .i_count  (r_count),
        .i_action (r_in_action),
        .i_key    (r_in_key),
        .o_state  (n_state),
        .o_count  (n_count),
        .o_flags  (w_flags)
    );

    // Commit state and result together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.floor_now   <= FLOOR_RESET;
            r_state.destination <= FLOOR_RESET;
            r_state.typed_value <= '0;
            r_state.travelling  <= 1'b0;
            r_state.upward      <= 1'b0;
            r_count             <= '0;
            r_out_valid         <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
                r_count <= n_count;
            end
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_data <= {2'b00, w_flags.rejected, w_flags.arrived,
                           n_state.upward, n_state.travelling,
                           n_state.typed_value, n_state.destination,
                           n_state.floor_now};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Arrival means the car sits at the target and has stopped
    a_arrive_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[44]) |->
            (r_out_data[13:0] == r_out_data[27:14]) && !r_out_data[42])
        else $error("arrival reported away from target");

    // A reject clears the entry and starts no move
    a_reject_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[45]) |->
            (r_out_data[41:28] == '0) && !r_out_data[42] && !r_out_data[44])
        else $error("reject left entry or motion");

    // Digit count stays within the entry length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRY_DIGITS))
        else $error("digit count past entry length");

    // Staged item is held while the result slot is blocked
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid && $stable(r_in_key)
            && $stable(r_in_action))
        else $error("staged item lost under stall");

    // State changes only when an item commits
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && r_in_valid) |=> $stable(r_state) && $stable(r_count))
        else $error("state changed without an item");

endmodule
